### design/sm83x_pkg.sv
package sm83x_pkg;

  // Instruction classes decided by the front end.
  typedef enum logic [3:0] {
    CLS_ILLEGAL,
    CLS_INCDEC8,
    CLS_LD8_IMM,
    CLS_LD16_IMM,
    CLS_INCDEC16,
    CLS_ADD_HL,
    CLS_LD_IND,
    CLS_NOP,
    CLS_ST_SP,
    CLS_STOP,
    CLS_JR,
    CLS_ACC_OP
  } op_class_t;

  // Write kinds on the result word.
  localparam logic [1:0] WK_NONE = 2'd0;
  localparam logic [1:0] WK_BYTE = 2'd1;
  localparam logic [1:0] WK_WORD = 2'd2;

  // Flag bit positions inside the four flag bits.
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // Decoded word passed from the front end to the back end.
  typedef struct packed {
    op_class_t   cls;
    logic [2:0]  r;
    logic [1:0]  p;
    logic        dec;
    logic        store;
    logic [1:0]  len;
    logic [15:0] immediate;
    logic [7:0]  read_data;
  } dec_word_t;

  // Instruction length in bytes from the opcode map.
  function automatic logic [1:0] op_length(input logic [7:0] op);
    logic [1:0] len;
    len = 2'd1;
    if (op[3:0] == 4'h1 || op == 8'h08) begin
      len = 2'd3;
    end else if (op[2:0] == 3'd6 || op == 8'h10 || op == 8'h18 || op == 8'h20 ||
                 op == 8'h28 || op == 8'h30 || op == 8'h38) begin
      len = 2'd2;
    end
    return len;
  endfunction

endpackage

### design/sm83x_decode.sv
module sm83x_decode (
  input  logic                  [7:0]  opcode,
  input  logic                  [15:0] immediate,
  input  logic                  [7:0]  read_data,
  output sm83x_pkg::dec_word_t         word
);
  import sm83x_pkg::*;

  // Classify the opcode into one execution class.
  always_comb begin
    word.r = opcode[5:3];
    word.p = opcode[5:4];
    word.dec = opcode[0];
    word.store = (opcode[3:0] == 4'h2);
    word.len = op_length(opcode);
    word.immediate = immediate;
    word.read_data = read_data;
    if (opcode[7:6] != 2'b00) begin
      word.cls = CLS_ILLEGAL;
    end else if (opcode[2:0] == 3'd4 || opcode[2:0] == 3'd5) begin
      word.cls = CLS_INCDEC8;
    end else if (opcode[2:0] == 3'd6) begin
      word.cls = CLS_LD8_IMM;
    end else if (opcode[3:0] == 4'h1) begin
      word.cls = CLS_LD16_IMM;
    end else if (opcode[3:0] == 4'h3 || opcode[3:0] == 4'hB) begin
      word.cls = CLS_INCDEC16;
    end else if (opcode[3:0] == 4'h9) begin
      word.cls = CLS_ADD_HL;
    end else if (opcode[3:0] == 4'h2 || opcode[3:0] == 4'hA) begin
      word.cls = CLS_LD_IND;
    end else if (opcode[2:0] == 3'd0) begin
      if (opcode == 8'h00) begin
        word.cls = CLS_NOP;
      end else if (opcode == 8'h08) begin
        word.cls = CLS_ST_SP;
      end else if (opcode == 8'h10) begin
        word.cls = CLS_STOP;
      end else begin
        word.cls = CLS_JR;
      end
    end else begin
      word.cls = CLS_ACC_OP;
    end
  end

endmodule

### design/sm83x_queue.sv
module sm83x_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sm83x_pkg::dec_word_t  in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sm83x_pkg::dec_word_t  out_word
);
  import sm83x_pkg::*;

  // Two-entry queue between decode and execute.
  dec_word_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_word = slots[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  // Pointer and occupancy control.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Payload storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_word;
    end
  end

endmodule

### design/sm83x_execute.sv
module sm83x_execute (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sm83x_pkg::dec_word_t  word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           pc_out,
  output logic [15:0]           af_out,
  output logic [15:0]           bc_out,
  output logic [15:0]           de_out,
  output logic [15:0]           hl_out,
  output logic [15:0]           sp_out,
  output logic [4:0]            cycle_count,
  output logic [1:0]            write_kind,
  output logic [15:0]           write_address,
  output logic [15:0]           write_data,
  output logic                  stopped_out,
  output logic                  illegal
);
  import sm83x_pkg::*;

  // Architectural state.
  logic [7:0]  acc;
  logic [3:0]  flags;
  logic [7:0]  regs [6];
  logic [15:0] sp;
  logic [15:0] pc;
  logic        stop;

  logic [7:0]  acc_next;
  logic [3:0]  flags_next;
  logic [7:0]  regs_next [6];
  logic [15:0] sp_next;
  logic [15:0] pc_next;
  logic        stop_next;
  logic [4:0]  cyc;
  logic [1:0]  wk;
  logic [15:0] wa;
  logic [15:0] wd;
  logic        ill;

  logic        fire;
  logic        out_busy;

  // The output register takes a new word whenever it is empty or being drained.
  assign in_ready = !out_busy || out_ready;
  assign fire = in_valid && in_ready;
  assign out_valid = out_busy;

  // Combinational execution of one instruction.
  always_comb begin
    logic [15:0] pair_v;
    logic [15:0] hl;
    logic [16:0] sum;
    logic [12:0] hsum;
    logic [7:0]  v8;
    logic [7:0]  res8;
    logic [7:0]  adj;
    logic        take;
    acc_next = acc;
    flags_next = flags;
    regs_next = regs;
    sp_next = sp;
    stop_next = stop;
    pc_next = pc + {14'd0, word.len};
    cyc = 5'd0;
    wk = WK_NONE;
    wa = 16'd0;
    wd = 16'd0;
    ill = 1'b0;
    hl = {regs[4], regs[5]};
    unique case (word.p)
      2'd0: pair_v = {regs[0], regs[1]};
      2'd1: pair_v = {regs[2], regs[3]};
      2'd2: pair_v = hl;
      default: pair_v = sp;
    endcase
    unique case (word.r)
      3'd6: v8 = word.read_data;
      3'd7: v8 = acc;
      default: v8 = regs[word.r];
    endcase
    sum = 17'd0;
    hsum = 13'd0;
    res8 = 8'd0;
    adj = 8'd0;
    take = 1'b0;
    unique case (word.cls)
      CLS_ILLEGAL: begin
        pc_next = pc;
        ill = 1'b1;
      end
      CLS_INCDEC8: begin
        res8 = word.dec ? v8 - 8'd1 : v8 + 8'd1;
        flags_next[FLAG_Z] = (res8 == 8'd0);
        flags_next[FLAG_N] = word.dec;
        flags_next[FLAG_H] = word.dec ? (res8[3:0] == 4'hF) : (res8[3:0] == 4'h0);
        if (word.r == 3'd6) begin
          wk = WK_BYTE;
          wa = hl;
          wd = {8'd0, res8};
          cyc = 5'd12;
        end else begin
          if (word.r == 3'd7) begin
            acc_next = res8;
          end else begin
            regs_next[word.r] = res8;
          end
          cyc = 5'd4;
        end
      end
      CLS_LD8_IMM: begin
        if (word.r == 3'd6) begin
          wk = WK_BYTE;
          wa = hl;
          wd = {8'd0, word.immediate[7:0]};
          cyc = 5'd12;
        end else begin
          if (word.r == 3'd7) begin
            acc_next = word.immediate[7:0];
          end else begin
            regs_next[word.r] = word.immediate[7:0];
          end
          cyc = 5'd8;
        end
      end
      CLS_LD16_IMM, CLS_INCDEC16: begin
        if (word.cls == CLS_LD16_IMM) begin
          sum = {1'b0, word.immediate};
          cyc = 5'd12;
        end else begin
          // Opcode bit 3 tells a 16-bit decrement from an increment.
          sum = {1'b0, word.r[0] ? pair_v - 16'd1 : pair_v + 16'd1};
          cyc = 5'd8;
        end
        unique case (word.p)
          2'd0: begin regs_next[0] = sum[15:8]; regs_next[1] = sum[7:0]; end
          2'd1: begin regs_next[2] = sum[15:8]; regs_next[3] = sum[7:0]; end
          2'd2: begin regs_next[4] = sum[15:8]; regs_next[5] = sum[7:0]; end
          default: sp_next = sum[15:0];
        endcase
      end
      CLS_ADD_HL: begin
        sum = {1'b0, hl} + {1'b0, pair_v};
        hsum = {1'b0, hl[11:0]} + {1'b0, pair_v[11:0]};
        flags_next[FLAG_N] = 1'b0;
        flags_next[FLAG_H] = hsum[12];
        flags_next[FLAG_C] = sum[16];
        regs_next[4] = sum[15:8];
        regs_next[5] = sum[7:0];
        cyc = 5'd8;
      end
      CLS_LD_IND: begin
        if (word.p[1]) begin
          pair_v = hl;
        end
        if (word.store) begin
          wk = WK_BYTE;
          wa = pair_v;
          wd = {8'd0, acc};
        end else begin
          acc_next = word.read_data;
        end
        if (word.p == 2'd2) begin
          {regs_next[4], regs_next[5]} = hl + 16'd1;
        end else if (word.p == 2'd3) begin
          {regs_next[4], regs_next[5]} = hl - 16'd1;
        end
        cyc = 5'd8;
      end
      CLS_NOP: cyc = 5'd4;
      CLS_ST_SP: begin
        wk = WK_WORD;
        wa = word.immediate;
        wd = sp;
        cyc = 5'd20;
      end
      CLS_STOP: begin
        stop_next = 1'b1;
        cyc = 5'd4;
      end
      CLS_JR: begin
        unique case (word.r)
          3'd3: take = 1'b1;
          3'd4: take = !flags[FLAG_Z];
          3'd5: take = flags[FLAG_Z];
          3'd6: take = !flags[FLAG_C];
          default: take = flags[FLAG_C];
        endcase
        if (take) begin
          pc_next = pc_next + {{8{word.immediate[7]}}, word.immediate[7:0]};
          cyc = 5'd12;
        end else begin
          cyc = 5'd8;
        end
      end
      default: begin
        // Accumulator rotates, DAA, CPL, SCF and CCF.
        cyc = 5'd4;
        unique case (word.r)
          3'd0: begin acc_next = {acc[6:0], acc[7]}; flags_next = {3'b000, acc[7]}; end
          3'd1: begin acc_next = {acc[0], acc[7:1]}; flags_next = {3'b000, acc[0]}; end
          3'd2: begin
            acc_next = {acc[6:0], flags[FLAG_C]};
            flags_next = {3'b000, acc[7]};
          end
          3'd3: begin
            acc_next = {flags[FLAG_C], acc[7:1]};
            flags_next = {3'b000, acc[0]};
          end
          3'd4: begin
            if (flags[FLAG_N]) begin
              adj = (flags[FLAG_H] ? 8'h06 : 8'h00) | (flags[FLAG_C] ? 8'h60 : 8'h00);
              res8 = acc - adj;
            end else begin
              if (flags[FLAG_H] || acc[3:0] > 4'h9) adj = adj | 8'h06;
              if (flags[FLAG_C] || acc > 8'h99) begin
                adj = adj | 8'h60;
                flags_next[FLAG_C] = 1'b1;
              end
              res8 = acc + adj;
            end
            acc_next = res8;
            flags_next[FLAG_H] = 1'b0;
            flags_next[FLAG_Z] = (res8 == 8'd0);
          end
          3'd5: begin
            acc_next = ~acc;
            flags_next[FLAG_N] = 1'b1;
            flags_next[FLAG_H] = 1'b1;
          end
          3'd6: flags_next = {flags[FLAG_Z], 3'b001};
          default: flags_next = {flags[FLAG_Z], 2'b00, !flags[FLAG_C]};
        endcase
      end
    endcase
  end

  // Commit state and load the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 8'd0;
      flags <= 4'd0;
      for (int i = 0; i < 6; i++) begin
        regs[i] <= 8'd0;
      end
      sp <= 16'd0;
      pc <= 16'd0;
      stop <= 1'b0;
      out_busy <= 1'b0;
    end else begin
      if (fire) begin
        acc <= acc_next;
        flags <= flags_next;
        regs <= regs_next;
        sp <= sp_next;
        pc <= pc_next;
        stop <= stop_next;
        out_busy <= 1'b1;
      end else if (out_ready) begin
        out_busy <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      pc_out <= pc_next;
      af_out <= {acc_next, flags_next, 4'd0};
      bc_out <= {regs_next[0], regs_next[1]};
      de_out <= {regs_next[2], regs_next[3]};
      hl_out <= {regs_next[4], regs_next[5]};
      sp_out <= sp_next;
      cycle_count <= cyc;
      write_kind <= wk;
      write_address <= wa;
      write_data <= wd;
      stopped_out <= stop_next;
      illegal <= ill;
    end
  end

endmodule

### design/cpu_opcode_block_00_3f_execute.sv
// Channel  Handshake                 Payload
// input    in_valid / in_ready       opcode, immediate, read_data
// output   out_valid / out_ready     pc_out .. illegal
// One word is accepted per cycle while the queue has room; a result passes
// through the decode queue, then the execute stage with its output register.
// The execute stage updates the register file in the cycle it takes a word,
// so throughput is one instruction per clock while the output is drained.
// Reset zeroes the CPU registers and empties the queue and the output register.
// An output stall fills the two-entry queue, after which in_ready drops.
module cpu_opcode_block_00_3f_execute (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  opcode,
  input  logic [15:0] immediate,
  input  logic [7:0]  read_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] pc_out,
  output logic [15:0] af_out,
  output logic [15:0] bc_out,
  output logic [15:0] de_out,
  output logic [15:0] hl_out,
  output logic [15:0] sp_out,
  output logic [4:0]  cycle_count,
  output logic [1:0]  write_kind,
  output logic [15:0] write_address,
  output logic [15:0] write_data,
  output logic        stopped_out,
  output logic        illegal
);
  import sm83x_pkg::*;

  dec_word_t dec_word;
  dec_word_t q_word;
  logic      q_valid;
  logic      q_ready;

  // Front end: classify the incoming word.
  sm83x_decode u_decode (
    .opcode    (opcode),
    .immediate (immediate),
    .read_data (read_data),
    .word      (dec_word)
  );

  // Queue between front and back.
  sm83x_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (dec_word),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_word  (q_word)
  );

  // Back end: execute and hold the result.
  sm83x_execute u_execute (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (q_valid),
    .in_ready      (q_ready),
    .word          (q_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pc_out        (pc_out),
    .af_out        (af_out),
    .bc_out        (bc_out),
    .de_out        (de_out),
    .hl_out        (hl_out),
    .sp_out        (sp_out),
    .cycle_count   (cycle_count),
    .write_kind    (write_kind),
    .write_address (write_address),
    .write_data    (write_data),
    .stopped_out   (stopped_out),
    .illegal       (illegal)
  );

endmodule

### design/sm83x_checker.sv
module sm83x_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] af_out,
  input logic [4:0]  cycle_count,
  input logic [1:0]  write_kind,
  input logic [15:0] write_address,
  input logic [15:0] write_data,
  input logic        stopped_out,
  input logic        illegal
);
  import sm83x_pkg::*;

  // Illegal words report no cycles and no write.
  a_illegal: assert property (@(posedge clk) disable iff (rst)
    out_valid && illegal |-> cycle_count == 5'd0 && write_kind == WK_NONE)
    else $error("illegal word with activity");

  // Without a write the address and data read as zero.
  a_nowrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_kind == WK_NONE |-> write_address == 16'd0 && write_data == 16'd0)
    else $error("stale write fields");

  // Low flag nibble is always zero.
  a_af: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> af_out[3:0] == 4'd0)
    else $error("af low bits set");

  // Stop flag is sticky across delivered words.
  a_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && stopped_out ##1 out_valid |-> stopped_out)
    else $error("stop flag cleared");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cycle_count))
    else $error("stalled result changed");

endmodule

bind cpu_opcode_block_00_3f_execute sm83x_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .af_out        (af_out),
  .cycle_count   (cycle_count),
  .write_kind    (write_kind),
  .write_address (write_address),
  .write_data    (write_data),
  .stopped_out   (stopped_out),
  .illegal       (illegal)
);
